FILE: hdl/rgbi_pkg.sv
// Shared types and codes for the regular-grid bilinear interpolator.
// Holds the register indexes, request codes and pipeline control struct.
// No dependencies.
package rgbi_pkg;

  // Configuration register indexes on the cfg_ write channel.
  typedef enum logic [2:0] {
    CFG_X_START    = 3'd0,
    CFG_Y_TOP      = 3'd1,
    CFG_INV_STEP_X = 3'd2,
    CFG_INV_STEP_Y = 3'd3,
    CFG_GRID_COLS  = 3'd4,
    CFG_GRID_ROWS  = 3'd5
  } cfg_reg_t;

  // Request codes carried by in_req_type.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Width of a linear grid address row*cols+col before wrapping to the store.
  localparam int ADDR_SPAN_W = 18;

  // Reset values of the configuration registers.
  localparam logic [31:0] INV_STEP_RESET = 32'h0001_0000;
  localparam logic [8:0]  GRID_DIM_RESET = 9'd2;

  // Control that travels with every item down the pipeline.
  // For a load, bad marks an index beyond the store; for a query, a point
  // outside the grid domain.
  typedef struct packed {
    logic valid;
    logic query;
    logic bad;
    logic last;
  } ctl_t;

  typedef logic signed [31:0] sample_t;

endpackage

FILE: hdl/regular_grid_bilinear_interpolator.sv
// Regular-grid bilinear interpolator, top level.
// Holds the grid store (two copies) and the whole interpolation pipeline.
// Depends on rgbi_pkg.

// The block keeps a row-major grid of signed Q16.16 samples and answers
// interpolation queries against it.
//
// Input channel: a beat is taken at a rising edge where start is high and busy
// is low. A load beat (in_req_type low) writes in_sample_value at
// in_sample_index and gives no result; an index beyond the store is dropped.
// A query beat (in_req_type high) gives exactly one result beat.
// Result channel: out_valid marks a result for one cycle. The receiver cannot
// stall, so nothing here ever waits on it; results leave in query order.
// Configuration: cfg_ready is always high; a write takes effect at the edge
// where cfg_valid is high. Write it only while no query is in flight.
//
// Pipeline: 12 stages plus the output register. One beat of either kind is
// taken every cycle while busy is low; the four corner reads come from two
// copies of the store, each read at two addresses per cycle.
// Loads write both copies in the same stage where queries read, so loads and
// queries act on the store in the order they were accepted.
//
// Reset: busy is high while rst_n is low and drops in the cycle after release;
// control, configuration and out_valid registers take their reset values; the
// grid store is not cleared, holds garbage until loaded, and has no clearing pass.
module regular_grid_bilinear_interpolator #(
  parameter int GRID_DEPTH = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 start,
  output logic                 busy,
  input  logic                 in_req_type,
  input  logic [15:0]          in_sample_index,
  input  logic signed [31:0]   in_sample_value,
  input  logic signed [31:0]   in_point_x,
  input  logic signed [31:0]   in_point_y,
  input  logic                 in_last_point,

  output logic                 out_valid,
  output logic signed [31:0]   out_interp_value,
  output logic                 out_status,
  output logic                 out_last_out,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int AW      = $clog2(GRID_DEPTH);
  localparam int SW      = rgbi_pkg::ADDR_SPAN_W;
  localparam int LATENCY = 13;

  // Configuration registers.
  logic signed [31:0] x_start_r;
  logic signed [31:0] y_top_r;
  logic [31:0]        inv_step_x_r;
  logic [31:0]        inv_step_y_r;
  logic [8:0]         grid_cols_r;
  logic [8:0]         grid_rows_r;

  logic               busy_r;

  // Pipeline control, one entry per stage.
  rgbi_pkg::ctl_t     ctl_r [1:12];
  rgbi_pkg::ctl_t     ctl1_nxt;
  rgbi_pkg::ctl_t     ctl2_nxt;
  rgbi_pkg::ctl_t     ctl3_nxt;
  logic               accept;

  // Stage 1: offsets from the origin, load address and data.
  logic signed [32:0] dx1_r;
  logic signed [32:0] dy1_r;
  logic               idx_ok;
  logic [AW-1:0]      ld_addr_r [1:6];
  logic [31:0]        ld_data_r [1:6];

  // Stage 2: scaled positions, Q32.32.
  logic [63:0]        px2_r;
  logic [63:0]        py2_r;
  logic               geom_bad;

  // Stage 3: cell base address and weights.
  logic [31:0]        lim_x;
  logic [31:0]        lim_y;
  logic               range_bad;
  logic [SW-1:0]      base3_r;
  logic [15:0]        fx_r [3:8];
  logic [15:0]        fy_r [3:11];

  // Stages 4 to 6: corner addresses, wrapped to the store.
  logic [SW-1:0]      span4_r [4];
  logic [AW-1:0]      addr6 [4];

  // Grid store, two copies: copy A serves the upper row, copy B the lower.
  logic [31:0]        store_a_r [GRID_DEPTH];
  logic [31:0]        store_b_r [GRID_DEPTH];
  logic               store_wr;

  // Stages 7 to 12: the blends.
  rgbi_pkg::sample_t  corner7_r [4];
  logic signed [32:0] dtop8_r;
  logic signed [32:0] dbot8_r;
  rgbi_pkg::sample_t  atop8_r;
  rgbi_pkg::sample_t  abot8_r;
  logic signed [49:0] ptop9_r;
  logic signed [49:0] pbot9_r;
  rgbi_pkg::sample_t  atop9_r;
  rgbi_pkg::sample_t  abot9_r;
  logic signed [33:0] top_sum;
  logic signed [33:0] bot_sum;
  rgbi_pkg::sample_t  top10_r;
  rgbi_pkg::sample_t  bot10_r;
  logic signed [32:0] diff11_r;
  rgbi_pkg::sample_t  top11_r;
  logic signed [49:0] pfin12_r;
  rgbi_pkg::sample_t  top12_r;
  logic signed [33:0] fin_sum;

  // Output registers.
  logic               out_valid_r;
  rgbi_pkg::sample_t  out_value_r;
  logic               out_status_r;
  logic               out_last_r;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_start_r    <= '0;
      y_top_r      <= '0;
      inv_step_x_r <= rgbi_pkg::INV_STEP_RESET;
      inv_step_y_r <= rgbi_pkg::INV_STEP_RESET;
      grid_cols_r  <= rgbi_pkg::GRID_DIM_RESET;
      grid_rows_r  <= rgbi_pkg::GRID_DIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rgbi_pkg::CFG_X_START:    x_start_r    <= cfg_data;
        rgbi_pkg::CFG_Y_TOP:      y_top_r      <= cfg_data;
        rgbi_pkg::CFG_INV_STEP_X: inv_step_x_r <= cfg_data;
        rgbi_pkg::CFG_INV_STEP_Y: inv_step_y_r <= cfg_data;
        rgbi_pkg::CFG_GRID_COLS:  grid_cols_r  <= cfg_data[8:0];
        rgbi_pkg::CFG_GRID_ROWS:  grid_rows_r  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Control for the three stages where an item's fate is decided. A load
  // beyond the store is marked bad at entry; a query picks up the domain
  // checks in stages 2 and 3.
  assign idx_ok = (32'(in_sample_index) < 32'(GRID_DEPTH));

  always_comb begin
    ctl1_nxt.valid = accept;
    ctl1_nxt.query = (in_req_type == rgbi_pkg::REQ_QUERY);
    ctl1_nxt.bad   = (in_req_type == rgbi_pkg::REQ_LOAD) && !idx_ok;
    ctl1_nxt.last  = in_last_point;
  end

  assign geom_bad = dx1_r[32] || dy1_r[32] || (grid_cols_r < 9'd2) || (grid_rows_r < 9'd2);

  always_comb begin
    ctl2_nxt     = ctl_r[1];
    ctl2_nxt.bad = ctl_r[1].bad || (ctl_r[1].query && geom_bad);
  end

  // A column count below two also underflows the limit, but that item is
  // already bad from stage 2.
  assign lim_x     = 32'(grid_cols_r) - 32'd2;
  assign lim_y     = 32'(grid_rows_r) - 32'd2;
  assign range_bad = (px2_r[63:32] > lim_x) || (py2_r[63:32] > lim_y);

  always_comb begin
    ctl3_nxt     = ctl_r[2];
    ctl3_nxt.bad = ctl_r[2].bad || (ctl_r[2].query && range_bad);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 12; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r[1] <= ctl1_nxt;
      ctl_r[2] <= ctl2_nxt;
      ctl_r[3] <= ctl3_nxt;
      for (int k = 4; k <= 12; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // Stage 1: exact 33-bit offsets; a set sign bit means the point lies left
  // of or above the origin.
  always_ff @(posedge clk) begin
    dx1_r <= {in_point_x[31], in_point_x} - {x_start_r[31], x_start_r};
    dy1_r <= {y_top_r[31], y_top_r} - {in_point_y[31], in_point_y};
    ld_addr_r[1] <= AW'(in_sample_index);
    ld_data_r[1] <= in_sample_value;
    for (int k = 2; k <= 6; k++) begin
      ld_addr_r[k] <= ld_addr_r[k-1];
      ld_data_r[k] <= ld_data_r[k-1];
    end
  end

  // Stage 2: position times inverse spacing. Only non-negative offsets are
  // used further on, so the low 32 bits are the full magnitude.
  always_ff @(posedge clk) begin
    px2_r <= 64'(dx1_r[31:0]) * 64'(inv_step_x_r);
    py2_r <= 64'(dy1_r[31:0]) * 64'(inv_step_y_r);
  end

  // Stage 3: cell base address. A good query has a cell index below 510,
  // so nine bits carry it.
  always_ff @(posedge clk) begin
    base3_r  <= SW'(py2_r[40:32] * grid_cols_r) + SW'(px2_r[40:32]);
    fx_r[3]  <= px2_r[31:16];
    fy_r[3]  <= py2_r[31:16];
    for (int k = 4; k <= 8; k++) begin
      fx_r[k] <= fx_r[k-1];
    end
    for (int k = 4; k <= 11; k++) begin
      fy_r[k] <= fy_r[k-1];
    end
  end

  // Stage 4: the four corner addresses, upper row first.
  always_ff @(posedge clk) begin
    span4_r[0] <= base3_r;
    span4_r[1] <= base3_r + SW'(1);
    span4_r[2] <= base3_r + SW'(grid_cols_r);
    span4_r[3] <= base3_r + SW'(grid_cols_r) + SW'(1);
  end

  // Stages 5 and 6: wrap each address to the store. A store at least as deep
  // as the largest address never wraps; otherwise the quotient comes from a
  // multiply by the reciprocal, exact for every address of SW bits.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    if (GRID_DEPTH >= (1 << SW)) begin : g_wide
      logic [SW-1:0] span5_r;
      logic [AW-1:0] addr6_r;

      always_ff @(posedge clk) begin
        span5_r <= span4_r[i];
        addr6_r <= AW'(span5_r);
      end

      assign addr6[i] = addr6_r;
    end else begin : g_wrap
      localparam int     SHIFT = SW + AW;
      localparam int     PW    = 2 * SW + 2;
      localparam longint RECIP = ((longint'(1) <<< SHIFT) + longint'(GRID_DEPTH) - 1)
                                 / longint'(GRID_DEPTH);
      logic [PW-1:0] prod;
      logic [SW-1:0] span5_r;
      logic [SW-1:0] quot5_r;
      logic [SW-1:0] qd;
      logic [AW-1:0] addr6_r;

      assign prod = PW'(span4_r[i]) * PW'(RECIP);
      assign qd   = SW'(quot5_r * SW'(GRID_DEPTH));

      always_ff @(posedge clk) begin
        span5_r <= span4_r[i];
        quot5_r <= SW'(prod >> SHIFT);
        addr6_r <= AW'(span5_r - qd);
      end

      assign addr6[i] = addr6_r;
    end
  end

  // Stage 6: the store. A load writes both copies; a query reads two corners
  // from each. One item sits in this stage per cycle, so a write and a query's
  // read never meet in the same cycle and program order is kept without forwarding.
  assign store_wr = ctl_r[6].valid && !ctl_r[6].query && !ctl_r[6].bad;

  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_a_r[ld_addr_r[6]] <= ld_data_r[6];
    end
    corner7_r[0] <= store_a_r[addr6[0]];
    corner7_r[1] <= store_a_r[addr6[1]];
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_b_r[ld_addr_r[6]] <= ld_data_r[6];
    end
    corner7_r[2] <= store_b_r[addr6[2]];
    corner7_r[3] <= store_b_r[addr6[3]];
  end

  // Each blend is computed as a + floor((b - a) * w / 65536), which equals
  // floor((a * (65536 - w) + b * w) / 65536) with a single multiply.
  always_ff @(posedge clk) begin
    dtop8_r <= {corner7_r[1][31], corner7_r[1]} - {corner7_r[0][31], corner7_r[0]};
    dbot8_r <= {corner7_r[3][31], corner7_r[3]} - {corner7_r[2][31], corner7_r[2]};
    atop8_r <= corner7_r[0];
    abot8_r <= corner7_r[2];
  end

  always_ff @(posedge clk) begin
    ptop9_r <= 50'(dtop8_r * $signed({1'b0, fx_r[8]}));
    pbot9_r <= 50'(dbot8_r * $signed({1'b0, fx_r[8]}));
    atop9_r <= atop8_r;
    abot9_r <= abot8_r;
  end

  // A blend lies between its inputs, so the low 32 bits hold it exactly.
  assign top_sum = {{2{atop9_r[31]}}, atop9_r} + ptop9_r[49:16];
  assign bot_sum = {{2{abot9_r[31]}}, abot9_r} + pbot9_r[49:16];

  always_ff @(posedge clk) begin
    top10_r <= top_sum[31:0];
    bot10_r <= bot_sum[31:0];
  end

  always_ff @(posedge clk) begin
    diff11_r <= {bot10_r[31], bot10_r} - {top10_r[31], top10_r};
    top11_r  <= top10_r;
  end

  always_ff @(posedge clk) begin
    pfin12_r <= 50'(diff11_r * $signed({1'b0, fy_r[11]}));
    top12_r  <= top11_r;
  end

  assign fin_sum = {{2{top12_r[31]}}, top12_r} + pfin12_r[49:16];

  // Output register: a strobe for every query, nothing for loads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_r[12].valid && ctl_r[12].query;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= ctl_r[12].bad ? '0 : fin_sum[31:0];
    out_status_r <= ctl_r[12].bad;
    out_last_r   <= ctl_r[12].last;
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_last_out     = out_last_r;

`ifndef SYNTH
  a_query_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req_type == rgbi_pkg::REQ_QUERY) |-> ##LATENCY out_valid)
    else $error("query beat did not produce a result at the expected cycle");

  a_load_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req_type == rgbi_pkg::REQ_LOAD) |-> ##LATENCY !out_valid)
    else $error("load beat produced a result");

  a_error_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_interp_value == 0))
    else $error("out-of-domain result carries a nonzero value");

  a_addr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[6].valid && ctl_r[6].query |->
      (32'(addr6[0]) < 32'(GRID_DEPTH)) && (32'(addr6[3]) < 32'(GRID_DEPTH)))
    else $error("wrapped corner address lies beyond the grid store");
`endif

endmodule
